// ===== rtl/core/sorted_list_engine_unit_defines.svh =====
// Assertion macros for the sorted list engine.
`ifndef SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is high.
`define SLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs during reset.
`define SLE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLE_ASSERT(label, clk, rst, prop, msg)
`define SLE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/sle_pkg.sv =====
// Shared types and constants of the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

  localparam int SLE_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE      = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t               cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/sle_req_if.sv =====
// Request channel: operation and value.
`timescale 1ns / 1ps
`default_nettype none
interface sle_req_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sle_rsp_if.sv =====
// Response channel: status, head, tail and count.
`timescale 1ns / 1ps
`default_nettype none
interface sle_rsp_if #(
  parameter int CNT_W = $clog2(sle_pkg::SLE_CAPACITY + 1)
);
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] head_entry;
  logic signed [DATA_W-1:0] tail_entry;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output status, output head_entry, output tail_entry,
                  output count, input ready);
  modport sink   (input valid, input status, input head_entry, input tail_entry,
                  input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sle_cell.sv =====
// One list cell: holds an entry, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sle_cell (
  input  wire logic                             clk,
  input  wire sle_pkg::cell_ctrl_t              ctrl,
  input  wire logic                             occ,
  input  wire logic signed [sle_pkg::DATA_W-1:0] left_entry,
  input  wire logic                             left_lt,
  input  wire logic signed [sle_pkg::DATA_W-1:0] right_entry,
  output logic signed [sle_pkg::DATA_W-1:0]      entry,
  output logic                                  lt,
  output logic                                  hit
);
  import sle_pkg::*;

  logic signed [DATA_W-1:0] entry_next;

  always_comb begin
    lt = occ && (entry < ctrl.value);
    hit = occ && (entry == ctrl.value);
  end

  always_comb begin
    entry_next = entry;
    case (ctrl.cmd)
      CELL_INSERT: begin
        if (!lt) begin
          entry_next = left_lt ? ctrl.value : left_entry;
        end
      end
      CELL_REMOVE: begin
        if (!lt) begin
          entry_next = right_entry;
        end
      end
      CELL_SHIFT: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_list_engine_unit.sv =====
// Top level of the sorted list engine: control, cell row and result register.
//
//  channel | dir | fields                                  | accepted when
//  req     | in  | op, value                               | valid && ready
//  rsp     | out | status, head_entry, tail_entry, count   | valid && ready
//
// The cell row and the count update at the edge that accepts an item; the next
// cycle loads head and tail into the response register. The control then moves
// from S_BUSY to S_OUT, holds the response there until rsp.ready is high, and
// returns to S_IDLE, where the next item can be taken.
// One item at a time: req.ready is high only while no response is pending.
// Reset clears the count and the control state; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_engine_unit_defines.svh"
module sorted_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::SLE_CAPACITY
) (
  input wire logic clk,
  input wire logic rst,
  sle_req_if.sink  req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [STATUS_W-1:0] status_r, status_next;
  logic signed [DATA_W-1:0] head_r, tail_r;
  logic signed [DATA_W-1:0] tail_sel;
  cell_ctrl_t ctrl;
  logic req_acc;
  logic found;

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY:0]   occ;
  logic [CAPACITY-1:0] last;

  assign occ[CAPACITY] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_e, right_e;
    logic left_l;

    assign occ[g] = (CNT_W'(g) < cnt);
    assign last[g] = occ[g] && !occ[g+1];

    if (g == 0) begin : g_first
      assign left_e = '0;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entry[g-1];
      assign left_l = lt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_e = entry[g];
    end else begin : g_inner
      assign right_e = entry[g+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[g]),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entry[g]),
      .lt          (lt[g]),
      .hit         (hit[g])
    );
  end

  assign found = |hit;

  // operation decode, applied on the accepting edge
  always_comb begin
    ctrl.cmd = CELL_HOLD;
    ctrl.value = req.value;
    cnt_next = cnt;
    status_next = status_r;
    if (req_acc) begin
      status_next = ST_DONE;
      case (req.op)
        OP_INSERT: begin
          if (cnt == CNT_W'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.cmd = CELL_INSERT;
            cnt_next = cnt + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (cnt == '0) begin
            status_next = ST_EMPTY;
          end else if (!found) begin
            status_next = ST_NOT_FOUND;
          end else begin
            ctrl.cmd = CELL_REMOVE;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        OP_REMOVE_HEAD: begin
          if (cnt == '0) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.cmd = CELL_SHIFT;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        OP_REMOVE_TAIL: begin
          if (cnt == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cnt_next = cnt - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          cnt_next = '0;
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  // one-hot select of the last occupied cell
  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_sel = tail_sel | (entry[i] & {DATA_W{last[i]}});
    end
  end

  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_next;
    if (state == S_BUSY) begin
      head_r <= occ[0] ? entry[0] : '0;
      tail_r <= tail_sel;
    end
  end

  assign rsp.status = status_r;
  assign rsp.head_entry = head_r;
  assign rsp.tail_entry = tail_r;
  assign rsp.count = cnt;

  `SLE_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(CAPACITY), "count above capacity")
  `SLE_ASSERT(a_acc_busy, clk, rst, req_acc |=> state == S_BUSY, "accept did not start work")
  `SLE_ASSERT(a_full_hold, clk, rst,
              (state == S_BUSY && status_r == ST_FULL) |-> $stable(cnt),
              "refused insert changed count")
  `SLE_ASSERT(a_empty_zero, clk, rst,
              (rsp.valid && cnt == '0) |-> (head_r == '0 && tail_r == '0),
              "empty list with nonzero head or tail")
  `SLE_ASSERT_RST(a_rst_clear, clk, rst |=> (cnt == '0 && state == S_IDLE),
                  "reset did not clear control")

endmodule
`default_nettype wire

// ===== tb/sv/tb_sorted_list_engine_unit.sv =====
// Testbench for the sorted list engine: directed table plus random phases, self-checking.
`timescale 1ns / 1ps
module tb_sorted_list_engine_unit;
  import sle_pkg::*;

  localparam int CNT_W = $clog2(SLE_CAPACITY + 1);
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_ITEMS  = 200;
  localparam int LIMIT_CYCLES = 200000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] tail;
    logic [CNT_W-1:0]         count;
  } list_snapshot_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic                     fixed;
    list_snapshot_t           want;
  } dir_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } phase_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     src_valid = 1'b0;
  logic [OP_W-1:0]          src_op    = '0;
  logic signed [DATA_W-1:0] src_value = '0;
  logic                     sink_ready = 1'b0;

  bit src_idle_en   = 1'b1;
  bit sink_stall_en = 1'b1;
  int stall_left    = 0;
  int cycle_count   = 0;
  int error_count   = 0;

  logic signed [DATA_W-1:0] shadow_vals [SLE_CAPACITY];
  int                       shadow_len = 0;
  list_snapshot_t           snapshot_q [$];
  dir_row_t                 dir_rows [$];
  list_snapshot_t           mon_want;

  sle_req_if req ();
  sle_rsp_if rsp ();

  assign req.valid = src_valid;
  assign req.op    = src_op;
  assign req.value = src_value;
  assign rsp.ready = sink_ready;

  sorted_list_engine_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (snapshot_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result: st=%0d head=%0d tail=%0d cnt=%0d",
                   rsp.status, rsp.head_entry, rsp.tail_entry, rsp.count);
      end else begin
        mon_want = snapshot_q.pop_front();
        if (rsp.status !== mon_want.status || rsp.head_entry !== mon_want.head ||
            rsp.tail_entry !== mon_want.tail || rsp.count !== mon_want.count) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("mismatch: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     mon_want.status, mon_want.head, mon_want.tail, mon_want.count,
                     rsp.status, rsp.head_entry, rsp.tail_entry, rsp.count);
        end
      end
    end
  end

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < shadow_len; i++)
      shadow_vals[i] = shadow_vals[i + 1];
    shadow_len--;
  endfunction

  function automatic list_snapshot_t predict_snapshot(input logic [OP_W-1:0] op,
                                                      input logic signed [DATA_W-1:0] v);
    list_snapshot_t snap;
    int pos;
    bit hit;
    snap.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= SLE_CAPACITY) begin
          snap.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_vals[pos] < v) pos++;
          for (int i = shadow_len; i > pos; i--)
            shadow_vals[i] = shadow_vals[i - 1];
          shadow_vals[pos] = v;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (shadow_len == 0) begin
          snap.status = ST_EMPTY;
        end else begin
          hit = 1'b0;
          for (int i = 0; i < shadow_len && !hit; i++) begin
            if (shadow_vals[i] == v) begin
              drop_entry(i);
              hit = 1'b1;
            end
          end
          if (!hit) snap.status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE_HEAD: begin
        if (shadow_len == 0) snap.status = ST_EMPTY;
        else drop_entry(0);
      end
      OP_REMOVE_TAIL: begin
        if (shadow_len == 0) snap.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    snap.head  = (shadow_len == 0) ? '0 : shadow_vals[0];
    snap.tail  = (shadow_len == 0) ? '0 : shadow_vals[shadow_len - 1];
    snap.count = CNT_W'(shadow_len);
    return snap;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1: v = int'($urandom_range(0, 16)) - 8;
      2: v = (shadow_len > 0) ? shadow_vals[$urandom_range(0, shadow_len - 1)] : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_stored();
    logic signed [DATA_W-1:0] v;
    if (shadow_len > 0 && $urandom_range(0, 9) < 7)
      v = shadow_vals[$urandom_range(0, shadow_len - 1)];
    else
      v = pick_value();
    return v;
  endfunction

  function automatic void add_checked(input logic [OP_W-1:0] op,
                                      input logic signed [DATA_W-1:0] v,
                                      input logic [STATUS_W-1:0] st,
                                      input logic signed [DATA_W-1:0] head,
                                      input logic signed [DATA_W-1:0] tail,
                                      input int cnt);
    dir_row_t r;
    r.op    = op;
    r.value = v;
    r.fixed = 1'b1;
    r.want  = '{st, head, tail, CNT_W'(cnt)};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_predicted(input logic [OP_W-1:0] op,
                                        input logic signed [DATA_W-1:0] v);
    dir_row_t r;
    r.op    = op;
    r.value = v;
    r.fixed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                           input logic fixed, input list_snapshot_t fixed_want);
    list_snapshot_t snap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_op    <= op;
    src_value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    snap = predict_snapshot(op, v);
    if (fixed) snap = fixed_want;
    snapshot_q.push_back(snap);
  endtask

  initial begin
    dir_row_t r;
    phase_mix_t mix;
    int sent;
    int phase_left;
    int phase_no;
    int pick;
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] v;

    // empty list corner cases
    add_checked(OP_REMOVE_HEAD, 0, ST_EMPTY, 0, 0, 0);
    add_checked(OP_REMOVE_TAIL, 0, ST_EMPTY, 0, 0, 0);
    add_checked(OP_REMOVE, 5, ST_EMPTY, 0, 0, 0);
    add_checked(OP_CLEAR, 0, ST_DONE, 0, 0, 0);
    add_checked(OP_SPARE_HI, -1, ST_DONE, 0, 0, 0);
    // fill to capacity, extremes and duplicates, then full, not-found, remove and clear cases
    add_checked(OP_INSERT, VAL_MAX, ST_DONE, VAL_MAX, VAL_MAX, 1);
    add_checked(OP_INSERT, VAL_MIN, ST_DONE, VAL_MIN, VAL_MAX, 2);
    add_predicted(OP_INSERT, 0);
    add_predicted(OP_INSERT, -1);
    add_predicted(OP_INSERT, 1);
    add_predicted(OP_INSERT, 0);
    add_predicted(OP_INSERT, 7);
    add_predicted(OP_INSERT, -7);
    add_predicted(OP_INSERT, 32'sh4000_0000);
    add_predicted(OP_INSERT, 32'shC000_0000);
    add_predicted(OP_INSERT, VAL_MAX);
    add_predicted(OP_INSERT, VAL_MIN);
    add_predicted(OP_INSERT, 32'sh5555_5555);
    add_predicted(OP_INSERT, 32'shAAAA_AAAA);
    add_predicted(OP_INSERT, 3);
    add_predicted(OP_INSERT, -3);
    add_checked(OP_INSERT, 42, ST_FULL, VAL_MIN, VAL_MAX, SLE_CAPACITY);
    add_checked(OP_REMOVE, 12345, ST_NOT_FOUND, VAL_MIN, VAL_MAX, SLE_CAPACITY);
    add_predicted(OP_REMOVE, 0);
    add_predicted(OP_REMOVE_TAIL, 0);
    add_predicted(OP_REMOVE_HEAD, 0);
    add_checked(OP_CLEAR, 0, ST_DONE, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item(r.op, r.value, r.fixed, r.want);
    end

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS - QUIET_ITEMS &&
          (phase_no == 0 || $urandom_range(0, 3) == 0)) begin
        src_valid <= 1'b0;
        @(posedge clk);
        while (snapshot_q.size() != 0) @(posedge clk);
      end
      mix = phase_mix_t'($urandom_range(0, 2));
      phase_left = $urandom_range(16, 80);
      if (sent < RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idle_en   = ($urandom_range(0, 3) != 0);
        sink_stall_en = ($urandom_range(0, 3) != 0);
      end
      while (phase_left > 0 && sent < RANDOM_ITEMS) begin
        if (sent == RANDOM_ITEMS - QUIET_ITEMS) begin
          src_idle_en   = 1'b0;
          sink_stall_en = 1'b0;
        end
        pick = $urandom_range(0, 99);
        v = pick_value();
        case (mix)
          MIX_FILL: begin
            if (pick < 75) op = OP_INSERT;
            else if (pick < 85) op = OP_REMOVE;
            else if (pick < 90) op = OP_REMOVE_HEAD;
            else if (pick < 95) op = OP_REMOVE_TAIL;
            else if (pick < 99) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else op = OP_CLEAR;
          end
          MIX_DRAIN: begin
            if (pick < 15) op = OP_INSERT;
            else if (pick < 55) op = OP_REMOVE;
            else if (pick < 75) op = OP_REMOVE_HEAD;
            else if (pick < 95) op = OP_REMOVE_TAIL;
            else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
          end
          default: op = OP_W'($urandom_range(0, 7));
        endcase
        if (op == OP_REMOVE) v = pick_stored();
        send_item(op, v, 1'b0, '0);
        sent++;
        phase_left--;
      end
      phase_no++;
    end

    src_valid <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && snapshot_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sorted_list_engine_unit.f =====
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_req_if.sv
rtl/core/sle_rsp_if.sv
rtl/core/sle_cell.sv
rtl/core/sorted_list_engine_unit.sv
tb/sv/tb_sorted_list_engine_unit.sv
